/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLKED(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Flag a condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLKED(lbl, !(cond), msg)

`endif

/* rtl/trpe_pkg.sv */
package trpe_pkg;

  // Kind of the last symbol handled in the current vector
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DATA = 2'd1,
    KIND_MISS = 2'd2
  } kind_t;

  // A missing run is emitted as soon as its count reaches this value
  localparam logic [6:0] RUN_SPLIT = 7'd126;

  // Last pair slot of a packed byte (bits 1..0)
  localparam logic [1:0] SLOT_LAST = 2'd3;

  // Result queue geometry; depth is a power of two, at least two
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_LW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] pack;
    logic [1:0] slot;
    logic [6:0] cnt;
    kind_t      kind;
  } enc_state_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       final_res;
  } res_t;

  // Results produced by one symbol, in output order
  typedef struct packed {
    logic [1:0] n;
    res_t       res0;
    res_t       res1;
  } emit_t;

  // Queue status seen by the input stage
  typedef struct packed {
    logic [Q_LW-1:0] level;
    logic            room;
  } q_stat_t;

endpackage

/* rtl/trpe_step.sv */
module trpe_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic [7:0]     symbol,
  input  logic           end_of_vector,
  output trpe_pkg::emit_t emit
);
  import trpe_pkg::*;

  enc_state_t st_r;
  enc_state_t st_nxt;
  enc_state_t st_aft;
  logic       is_data;
  logic [1:0] pair;
  logic [7:0] pack_new;
  logic [6:0] cnt_inc;
  logic       a_v;
  logic       b_v;
  logic       c_v;
  logic [7:0] a_byte;
  logic [7:0] b_byte;
  logic [7:0] c_byte;
  logic [1:0] n_all;

  // Work out the bytes caused by one symbol and the state it leaves
  always_comb begin
    is_data = (symbol[7:1] == 7'd0);
    pair    = {1'b1, symbol[0]};
    case (st_r.slot)
      2'd0:    pack_new = st_r.pack | {pair, 6'b0};
      2'd1:    pack_new = st_r.pack | {2'b0, pair, 4'b0};
      2'd2:    pack_new = st_r.pack | {4'b0, pair, 2'b0};
      default: pack_new = st_r.pack | {6'b0, pair};
    endcase
    cnt_inc = st_r.cnt + 7'd1;
    st_aft  = st_r;

    if (is_data) begin
      // close a pending missing run, then add the pair
      a_v         = (st_r.kind == KIND_MISS) && (st_r.cnt != 7'd0);
      a_byte      = {1'b0, st_r.cnt};
      b_v         = (st_r.slot == SLOT_LAST);
      b_byte      = pack_new;
      st_aft.cnt  = a_v ? 7'd0 : st_r.cnt;
      st_aft.pack = b_v ? 8'd0 : pack_new;
      st_aft.slot = st_r.slot + 2'd1;
      st_aft.kind = KIND_DATA;
      c_v         = end_of_vector && (st_aft.pack != 8'd0);
      c_byte      = st_aft.pack;
    end else begin
      // close a partly filled byte, then extend the run
      a_v         = (st_r.kind == KIND_DATA) && (st_r.pack != 8'd0);
      a_byte      = st_r.pack;
      st_aft.pack = a_v ? 8'd0 : st_r.pack;
      st_aft.slot = a_v ? 2'd0 : st_r.slot;
      b_v         = (cnt_inc >= RUN_SPLIT);
      b_byte      = {1'b0, cnt_inc};
      st_aft.cnt  = b_v ? 7'd0 : cnt_inc;
      st_aft.kind = KIND_MISS;
      c_v         = end_of_vector && (st_aft.cnt != 7'd0);
      c_byte      = {1'b0, st_aft.cnt};
    end

    n_all = {1'b0, a_v} + {1'b0, b_v} + {1'b0, c_v};

    // Order the results; the last one of a vector carries the final mark
    emit.n              = step_en ? n_all : 2'd0;
    emit.res0.code_byte = a_v ? a_byte : (b_v ? b_byte : c_byte);
    emit.res0.final_res = end_of_vector && (n_all == 2'd1);
    emit.res1.code_byte = (a_v && b_v) ? b_byte : c_byte;
    emit.res1.final_res = end_of_vector;

    // End of vector returns everything to reset
    if (end_of_vector) begin
      st_nxt = '{pack: 8'd0, slot: 2'd0, cnt: 7'd0, kind: KIND_NONE};
    end else begin
      st_nxt = st_aft;
    end
  end

  // Hold encoder state, advance on each processed symbol
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{pack: 8'd0, slot: 2'd0, cnt: 7'd0, kind: KIND_NONE};
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

/* rtl/trpe_res_queue.sv */
module trpe_res_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  trpe_pkg::emit_t   emit,
  output trpe_pkg::q_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_code_byte,
  output logic              out_final_res
);
  import trpe_pkg::*;

  res_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r;
  logic [Q_AW-1:0] rd_r;
  logic [Q_LW-1:0] level_r;
  logic [Q_AW-1:0] wr_nxt;
  logic [Q_AW-1:0] rd_nxt;
  logic [Q_LW-1:0] level_nxt;
  logic            pop;

  // Present the oldest result
  assign out_valid     = (level_r != '0);
  assign out_code_byte = mem_r[rd_r].code_byte;
  assign out_final_res = mem_r[rd_r].final_res;
  assign pop           = out_valid && out_ready;

  // Room for the largest burst one symbol can push
  assign stat.level = level_r;
  assign stat.room  = (level_r <= Q_LW'(Q_DEPTH - 2));

  assign wr_nxt    = wr_r + Q_AW'(emit.n);
  assign rd_nxt    = rd_r + Q_AW'(pop);
  assign level_nxt = level_r + Q_LW'(emit.n) - Q_LW'(pop);

  // Store up to two results per cycle
  always_ff @(posedge clk) begin
    if (emit.n != 2'd0) begin
      mem_r[wr_r] <= emit.res0;
    end
    if (emit.n == 2'd2) begin
      mem_r[wr_r + Q_AW'(1)] <= emit.res1;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

/* rtl/ternary_run_pack_encoder.sv */
// Ternary run/pack encoder. Takes one symbol per transaction (0 or 1 is data,
// any other value is missing) and returns compressed code bytes: data packed
// four to a byte as flag/value pairs from bit 7 down, missing runs as a byte
// with bit 7 clear and a 7-bit count that splits at 126. end_of_vector
// flushes what is pending and marks the last byte with final_res. A symbol
// is accepted every cycle while the queue has room; it is held in the input
// register, then encoded into a four-entry result queue, whose oldest byte
// is presented at the output. A symbol yields zero, one or two bytes; the
// output drains one byte per cycle while out_ready is high, so sustained
// rate is one symbol per cycle as long as symbols average no more than one
// byte, and the input stalls while the queue cannot take a two-byte burst.
`include "assert_macros.svh"

module ternary_run_pack_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_symbol,
  input  logic       in_end_of_vector,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_code_byte,
  output logic       out_final_res
);
  import trpe_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_sym_r;
  logic       in_eov_r;
  logic       fire;
  emit_t      step_emit;
  q_stat_t    q_stat;

  // Process the held symbol when the queue has room for a burst
  assign fire     = in_vld_r && q_stat.room;
  assign in_ready = !in_vld_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_sym_r <= in_symbol;
      in_eov_r <= in_end_of_vector;
    end
  end

  trpe_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (fire),
    .symbol        (in_sym_r),
    .end_of_vector (in_eov_r),
    .emit          (step_emit)
  );

  trpe_res_queue u_queue (
    .clk           (clk),
    .rst_n         (rst_n),
    .emit          (step_emit),
    .stat          (q_stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_byte (out_code_byte),
    .out_final_res (out_final_res)
  );

  // A vector always closes with at least one byte
  `ASSERT_CLKED(a_eov_emits, fire && in_eov_r |-> step_emit.n != 2'd0,
                "end of vector produced no byte")
  // One symbol never yields three bytes
  `ASSERT_NEVER(a_no_triple, step_emit.n == 2'd3, "symbol produced three bytes")
  // Queue never overfills
  `ASSERT_NEVER(a_q_bound, q_stat.level > Q_LW'(Q_DEPTH), "result queue overflow")

endmodule
